// ----- hw/rtl/lpst_pkg.sv -----
`default_nettype none

package lpst_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = 5;
  localparam int KEY_W  = 31;
  localparam int STAT_W = 4;
  localparam logic [IDX_W-1:0] SLOT_COUNT_RESET = IDX_W'(SLOTS);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MOVE   = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PLACED       = 4'd0,
    ST_PLACED_PROBE = 4'd1,
    ST_FULL         = 4'd2,
    ST_IGNORED      = 4'd3,
    ST_REMOVED      = 4'd4,
    ST_NOT_FOUND    = 4'd5,
    ST_MOVED        = 4'd6,
    ST_MOVED_PROBE  = 4'd7,
    ST_LIST_ENTRY   = 4'd8,
    ST_LIST_EMPTY   = 4'd9
  } status_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS-1:0] vec);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  // bits at and above pos
  function automatic logic [SLOTS-1:0] from_mask(input logic [IDX_W-1:0] pos);
    logic [SLOTS-1:0] below;
    below = (SLOTS'(1) << pos) - SLOTS'(1);
    return ~below;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/linear_probe_slot_table.sv -----
// Slot table with linear probing, sixteen slots of 31-bit keys.
// Request channel in_*: operation (insert, remove, move, list), key, slot and
// move target; one beat per request. Result channel out_*: status, slot, key
// and last; every request gives one result beat, a list request gives one beat
// per occupied active slot in ascending order (or one list-empty beat), the
// final beat of a request carrying last.
// Configuration channel cfg_*: active slot count, always ready; write it only
// while no request is in flight.
// Steps: a request is taken in the idle state, which starts its key memory
// read; the read data returns in the execute state, where the result is formed
// and registered, so insert, remove and move each pass idle and execute.
// A list request goes from idle to a read state and a result state per occupied
// slot, the read state being the key memory read. Free slots are found
// combinationally by a wrapping priority search over the occupancy bits.
// A finished result waits in the output register while the next request is
// taken; a stalled receiver holds the block in its result cycle until the
// register frees.
// Reset empties the table (occupancy bits cleared, keys left as they are) and
// sets the slot count to sixteen.
`default_nettype none

module linear_probe_slot_table
  import lpst_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [1:0]           in_operation,
  input  wire  [KEY_W-1:0]     in_item_key,
  input  wire  [IDX_W-1:0]     in_slot_index,
  input  wire  [IDX_W-1:0]     in_target_slot,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [SLOT_W-1:0]    out_result_slot,
  output logic [KEY_W-1:0]     out_result_key,
  output logic                 out_last,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [IDX_W-1:0]     cfg_slot_count
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_EXEC    = 4'b0010,
    S_LIST_RD = 4'b0100,
    S_LIST_WR = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [KEY_W-1:0]   key_r;
  logic [IDX_W-1:0]   slot_r;
  logic [IDX_W-1:0]   target_r;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic [SLOT_W-1:0]  pick_r, pick_nxt;
  logic               lastent_r, lastent_nxt;
  logic [IDX_W-1:0]   slot_count_r;
  logic [SLOTS-1:0]   occupied_r, occupied_nxt;

  logic [KEY_W-1:0]   key_mem [SLOTS];
  logic [KEY_W-1:0]   rdata_r;
  logic               mem_re, mem_we;
  logic [SLOT_W-1:0]  mem_ra, mem_wa;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_load, out_free;

  logic [IDX_W-1:0]   active_n;
  logic [SLOTS-1:0]   active_mask;
  logic               in_range, tgt_ok, hit, none_free;
  logic [SLOT_W-1:0]  start, pos;
  logic [SLOTS-1:0]   free_v, upper;
  logic [SLOTS-1:0]   list_mask, list_rest;

  assign active_n = (slot_count_r > IDX_W'(SLOTS)) ? IDX_W'(SLOTS) : slot_count_r;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      active_mask[i] = IDX_W'(i) < active_n;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // request decode against registered read data
  assign in_range = slot_r < active_n;
  assign tgt_ok   = target_r < active_n;
  assign hit      = occupied_r[slot_r[SLOT_W-1:0]] && (rdata_r == key_r);
  assign start    = (op_r == OP_MOVE) ? target_r[SLOT_W-1:0] : slot_r[SLOT_W-1:0];

  always_comb begin
    free_v = ~occupied_r & active_mask;
    if (op_r == OP_MOVE) free_v[slot_r[SLOT_W-1:0]] = 1'b1;
  end

  assign upper     = free_v & from_mask({1'b0, start});
  assign none_free = (free_v == '0);
  assign pos       = (upper != '0) ? lowest_set(upper) : lowest_set(free_v);

  // list scan
  assign list_mask = occupied_r & active_mask & from_mask(scan_r);
  assign list_rest = list_mask & (list_mask - SLOTS'(1));

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    pick_nxt       = pick_r;
    lastent_nxt    = lastent_r;
    occupied_nxt   = occupied_r;
    mem_re         = 1'b0;
    mem_ra         = in_slot_index[SLOT_W-1:0];
    mem_we         = 1'b0;
    mem_wa         = pos;
    out_load       = 1'b0;
    out_status_nxt = ST_IGNORED;
    out_slot_nxt   = '0;
    out_key_nxt    = '0;
    out_last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mem_re   = 1'b1;
          scan_nxt = '0;
          state_nxt = (op_t'(in_operation) == OP_LIST) ? S_LIST_RD : S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (!in_range) begin
            out_status_nxt = ST_IGNORED;
          end else begin
            case (op_r)
              OP_INSERT: begin
                if (none_free) begin
                  out_status_nxt = ST_FULL;
                end else begin
                  mem_we            = 1'b1;
                  occupied_nxt[pos] = 1'b1;
                  out_slot_nxt      = pos;
                  out_status_nxt    = (pos == start) ? ST_PLACED : ST_PLACED_PROBE;
                end
              end
              OP_REMOVE: begin
                if (!hit) begin
                  out_status_nxt = ST_NOT_FOUND;
                end else begin
                  occupied_nxt[slot_r[SLOT_W-1:0]] = 1'b0;
                  out_slot_nxt   = slot_r[SLOT_W-1:0];
                  out_status_nxt = ST_REMOVED;
                end
              end
              OP_MOVE: begin
                if (!hit || !tgt_ok) begin
                  out_status_nxt = ST_NOT_FOUND;
                end else begin
                  mem_we = 1'b1;
                  occupied_nxt[slot_r[SLOT_W-1:0]] = 1'b0;
                  occupied_nxt[pos] = 1'b1;
                  out_slot_nxt      = pos;
                  out_status_nxt    = (pos == start) ? ST_MOVED : ST_MOVED_PROBE;
                end
              end
              default: begin
                out_status_nxt = ST_IGNORED;
              end
            endcase
          end
        end
      end

      S_LIST_RD: begin
        if (list_mask != '0) begin
          mem_re      = 1'b1;
          mem_ra      = lowest_set(list_mask);
          pick_nxt    = lowest_set(list_mask);
          lastent_nxt = (list_rest == '0);
          state_nxt   = S_LIST_WR;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = ST_LIST_EMPTY;
          state_nxt      = S_IDLE;
        end
      end

      S_LIST_WR: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = ST_LIST_ENTRY;
          out_slot_nxt   = pick_r;
          out_key_nxt    = rdata_r;
          out_last_nxt   = lastent_r;
          scan_nxt       = IDX_W'(pick_r) + IDX_W'(1);
          state_nxt      = lastent_r ? S_IDLE : S_LIST_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occupied_r   <= '0;
      slot_count_r <= SLOT_COUNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occupied_r  <= occupied_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) slot_count_r <= cfg_slot_count;
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    pick_r    <= pick_nxt;
    lastent_r <= lastent_nxt;
    if (in_valid && in_ready) begin
      op_r     <= op_t'(in_operation);
      key_r    <= in_item_key;
      slot_r   <= in_slot_index;
      target_r <= in_target_slot;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_key_r    <= out_key_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // key memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) key_mem[mem_wa] <= key_r;
    if (mem_re) rdata_r <= key_mem[mem_ra];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_slot_r;
  assign out_result_key  = out_key_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/lpst_checker.sv -----
`default_nettype none

module lpst_checker
  import lpst_pkg::*;
(
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire [STAT_W-1:0]    out_status,
  input wire [SLOT_W-1:0]    out_result_slot,
  input wire [KEY_W-1:0]     out_result_key,
  input wire                 out_last
);

  // stalled beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_result_slot) && $stable(out_result_key) && $stable(out_last))
    else $error("stalled result beat changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_LIST_EMPTY)
    else $error("status code out of range");

  // only list entries can be non-final
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_LIST_ENTRY |-> out_last)
    else $error("single result beat without last");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_IGNORED
      || out_status == ST_NOT_FOUND || out_status == ST_LIST_EMPTY)
      |-> out_result_slot == '0 && out_result_key == '0)
    else $error("failed request carries slot or key");

endmodule

bind linear_probe_slot_table lpst_checker u_lpst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_result_slot (out_result_slot),
  .out_result_key  (out_result_key),
  .out_last        (out_last)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import lpst_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic              last;
  } slot_result_t;

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // shadow of the slot table and the results it owes
  class slot_table_scoreboard;
    logic [SLOTS-1:0] occupied;
    logic [KEY_W-1:0] keys [SLOTS];
    logic [IDX_W-1:0] slot_count;
    slot_result_t     owed_q [$];
    int               errors;

    function new();
      occupied   = '0;
      slot_count = SLOT_COUNT_RESET;
      errors     = 0;
    endfunction

    function int active_count();
      return (slot_count > SLOTS) ? SLOTS : int'(slot_count);
    endfunction

    function int free_from(int start, int n);
      int s;
      for (int i = 0; i < n; i++) begin
        s = (start + i) % n;
        if (!occupied[s]) return s;
      end
      return n;
    endfunction

    function void owe(status_t st, int slot, logic [KEY_W-1:0] key, logic last);
      slot_result_t r;
      r.status = st;
      r.slot   = SLOT_W'(slot);
      r.key    = key;
      r.last   = last;
      owed_q.push_back(r);
    endfunction

    function void place(int s, logic [KEY_W-1:0] key);
      keys[s]     = key;
      occupied[s] = 1'b1;
    endfunction

    function void note_request(op_t op, logic [KEY_W-1:0] key, logic [IDX_W-1:0] slot,
                               logic [IDX_W-1:0] target);
      int n;
      int found;
      int pos;
      n = active_count();
      found = 0;
      if (op == OP_LIST) begin
        for (int s = 0; s < n; s++) begin
          if (occupied[s]) begin
            owe(ST_LIST_ENTRY, s, keys[s], 1'b0);
            found++;
          end
        end
        if (found == 0) owe(ST_LIST_EMPTY, 0, '0, 1'b1);
        else owed_q[owed_q.size()-1].last = 1'b1;
      end else if (slot >= n) begin
        owe(ST_IGNORED, 0, '0, 1'b1);
      end else if (op == OP_INSERT) begin
        if (!occupied[slot[SLOT_W-1:0]]) begin
          place(slot, key);
          owe(ST_PLACED, slot, '0, 1'b1);
        end else begin
          pos = free_from(slot, n);
          if (pos >= n) begin
            owe(ST_FULL, 0, '0, 1'b1);
          end else begin
            place(pos, key);
            owe(ST_PLACED_PROBE, pos, '0, 1'b1);
          end
        end
      end else if (!occupied[slot[SLOT_W-1:0]] || keys[slot[SLOT_W-1:0]] != key) begin
        owe(ST_NOT_FOUND, 0, '0, 1'b1);
      end else if (op == OP_REMOVE) begin
        occupied[slot[SLOT_W-1:0]] = 1'b0;
        owe(ST_REMOVED, slot, '0, 1'b1);
      end else if (target >= n) begin
        owe(ST_NOT_FOUND, 0, '0, 1'b1);
      end else begin
        occupied[slot[SLOT_W-1:0]] = 1'b0;
        if (!occupied[target[SLOT_W-1:0]]) begin
          place(target, key);
          owe(ST_MOVED, target, '0, 1'b1);
        end else begin
          pos = free_from(target, n);
          place(pos, key);
          owe(ST_MOVED_PROBE, pos, '0, 1'b1);
        end
      end
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result status %0d slot %0d key %h last %0b",
                 $time, got.status, got.slot, got.key, got.last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.status != want.status || got.slot != want.slot || got.key != want.key ||
          got.last != want.last) begin
        $display({"%0t: expected status %0d slot %0d key %h last %0b, ",
                  "got status %0d slot %0d key %h last %0b"},
                 $time, want.status, want.slot, want.key, want.last,
                 got.status, got.slot, got.key, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_operation;
  logic [KEY_W-1:0]  in_item_key;
  logic [IDX_W-1:0]  in_slot_index;
  logic [IDX_W-1:0]  in_target_slot;
  logic              out_valid;
  logic              out_ready;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_result_slot;
  logic [KEY_W-1:0]  out_result_key;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_slot_count;

  slot_table_scoreboard sb;
  bit                   long_hold;

  linear_probe_slot_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_item_key     (in_item_key),
    .in_slot_index   (in_slot_index),
    .in_target_slot  (in_target_slot),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_slot (out_result_slot),
    .out_result_key  (out_result_key),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_slot_count  (cfg_slot_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // results are checked before the same edge's request is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result({status_t'(out_status), out_result_slot, out_result_key, out_last});
      if (in_valid && in_ready)
        sb.note_request(op_t'(in_operation), in_item_key, in_slot_index, in_target_slot);
      if (cfg_valid && cfg_ready)
        sb.slot_count = cfg_slot_count;
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int period;
    int hold_left;
    int tick;
    bit hold_taken;
    mode_left  = 0;
    hold_left  = 0;
    tick       = 0;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_taken) begin
        hold_left  = 300;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
          period    = $urandom_range(2, 5);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = (tick % period) == 0;
          default: out_ready = $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
                              input logic [IDX_W-1:0] slot, input logic [IDX_W-1:0] target);
    @(negedge clk);
    in_valid       = 1'b1;
    in_operation   = op;
    in_item_key    = key;
    in_slot_index  = slot;
    in_target_slot = target;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [IDX_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid      = 1'b1;
    cfg_slot_count = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 9);
    k = KEY_W'($urandom());
    if (r == 0) return '0;
    if (r == 1) return KEY_MAX;
    return k;
  endfunction

  function automatic logic [IDX_W-1:0] pick_slot(int n);
    if (n == 0 || $urandom_range(0, 99) < 15) return IDX_W'($urandom_range(0, 31));
    return IDX_W'($urandom_range(0, n - 1));
  endfunction

  // mostly well-formed: removes and moves aim at a stored key
  task automatic pick_request(output op_t op, output logic [KEY_W-1:0] key,
                              output logic [IDX_W-1:0] slot, output logic [IDX_W-1:0] target);
    int n;
    int r;
    int used [$];
    n = sb.active_count();
    r = $urandom_range(0, 99);
    key    = pick_key();
    slot   = pick_slot(n);
    target = pick_slot(n);
    for (int s = 0; s < n; s++)
      if (sb.occupied[s]) used.push_back(s);
    if (r < 8) begin
      op     = op_t'($urandom_range(0, 3));
      slot   = IDX_W'($urandom_range(0, 31));
      target = IDX_W'($urandom_range(0, 31));
    end else if (r < 48) begin
      op = OP_INSERT;
    end else if (r < 88) begin
      op = (r < 66) ? OP_REMOVE : OP_MOVE;
      if (used.size() != 0 && $urandom_range(0, 9) != 0) begin
        slot = IDX_W'(used[$urandom_range(0, used.size() - 1)]);
        key  = sb.keys[slot[SLOT_W-1:0]];
      end
    end else begin
      op = OP_LIST;
    end
  endtask

  task automatic run_random(input int count);
    int burst_left;
    int gap;
    op_t op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] target;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(0, 5);
        if (gap > 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      pick_request(op, key, slot, target);
      send_request(op, key, slot, target);
      burst_left--;
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_INSERT;
    in_item_key    = '0;
    in_slot_index  = '0;
    in_target_slot = '0;
    cfg_valid      = 1'b0;
    cfg_slot_count = SLOT_COUNT_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed beats on the full sixteen slots
    send_request(OP_LIST,   '0,          5'd0,  5'd0);
    send_request(OP_INSERT, '0,          5'd0,  5'd31);
    send_request(OP_INSERT, KEY_MAX,     5'd15, 5'd0);
    send_request(OP_INSERT, 31'd5,       5'd15, 5'd0);
    send_request(OP_INSERT, 31'd9,       5'd16, 5'd0);
    send_request(OP_INSERT, 31'd9,       5'd31, 5'd0);
    send_request(OP_REMOVE, 31'd1,       5'd0,  5'd0);
    send_request(OP_REMOVE, 31'd1,       5'd3,  5'd0);
    send_request(OP_REMOVE, '0,          5'd0,  5'd0);
    send_request(OP_MOVE,   31'd5,       5'd1,  5'd1);
    send_request(OP_MOVE,   31'd5,       5'd1,  5'd15);
    send_request(OP_MOVE,   KEY_MAX,     5'd15, 5'd20);
    send_request(OP_MOVE,   KEY_MAX,     5'd31, 5'd0);
    send_request(OP_LIST,   '0,          5'd0,  5'd0);

    // one slot: full table and hidden entries
    write_slot_count(5'd1);
    send_request(OP_INSERT, 31'h2AAA_AAAA, 5'd0, 5'd0);
    send_request(OP_INSERT, 31'h5555_5555, 5'd0, 5'd0);
    send_request(OP_MOVE,   31'h2AAA_AAAA, 5'd0, 5'd0);
    send_request(OP_LIST,   '0,            5'd0, 5'd0);
    send_request(OP_INSERT, 31'd3,         5'd1, 5'd0);
    write_slot_count(5'd0);
    send_request(OP_LIST,   '0,            5'd0, 5'd0);
    send_request(OP_INSERT, 31'd3,         5'd0, 5'd0);
    write_slot_count(5'd16);
    send_request(OP_LIST,   '0,            5'd0, 5'd0);

    run_random(90);
    write_slot_count(5'd5);
    run_random(60);
    write_slot_count(5'd31);
    run_random(60);
    write_slot_count(5'd1);
    run_random(30);
    write_slot_count(5'd0);
    run_random(8);
    write_slot_count(5'd3);
    run_random(50);
    write_slot_count(5'd16);
    long_hold = 1'b1;
    run_random(45);
    wait_drained();
    run_random(45);
    write_slot_count(5'd12);
    run_random(60);
    write_slot_count(5'd2);
    run_random(40);
    write_slot_count(5'd16);
    run_random(30);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
